FILE: rtl/fsa_pkg.sv
`default_nettype none

package fsa_pkg;

    // Overflow status carried with a result.
    typedef enum logic {
        OVF_NONE = 1'b0,
        OVF_SET  = 1'b1
    } t_ovf;

endpackage

`default_nettype wire

FILE: rtl/fraction_sum_accumulator_top.sv
// An accepted transaction passes the bit-serial multiply, the sum, the data-dependent gcd states
// (zero test, power-of-two strip, subtract loop, restore) and the bit-serial dividers over W bits,
// W = ACC_WIDTH + IN_WIDTH + 1. A zero denominator goes straight from acceptance to S_DONE.
// The input stalls until the sequencer is idle again, so a new transaction is accepted only
// after the previous one has been loaded into the output register.
// Synchronous active-low reset returns the sum to 0/1 and empties the output register.
`default_nettype none

module fraction_sum_accumulator_top #(
    parameter int ACC_WIDTH = 32,
    parameter int IN_WIDTH  = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic                 i_restart,
    input  wire logic [IN_WIDTH-1:0]  i_addend_num,
    input  wire logic [IN_WIDTH-1:0]  i_addend_den,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [ACC_WIDTH-1:0]      o_sum_num,
    output logic [ACC_WIDTH-1:0]      o_sum_den,
    output logic                      o_overflow
);

    // The unreduced sum needs ACC_WIDTH + IN_WIDTH bits plus one carry bit.
    localparam int W  = ACC_WIDTH + IN_WIDTH + 1;
    localparam int CW = $clog2(W + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_GZERO,
        S_GTWO,
        S_GAEVEN,
        S_GLOOP,
        S_GSHIFT,
        S_DIV,
        S_DONE
    } t_state;

    t_state r_state;

    // Running sum, the state that survives between transactions.
    logic [ACC_WIDTH-1:0] r_run_num;
    logic [ACC_WIDTH-1:0] r_run_den;

    // Multiplier bits are shifted out of these registers, most significant bit first.
    logic [IN_WIDTH-1:0]  r_sad;
    logic [IN_WIDTH-1:0]  r_san;

    // Partial products; later r_pn and r_pd hold dividend bits and then quotient bits.
    logic [W-1:0]         r_pn;
    logic [W-1:0]         r_pd;
    logic [W-1:0]         r_pt;

    // Binary gcd operands; r_a ends up as the divisor.
    logic [W-1:0]         r_a;
    logic [W-1:0]         r_b;
    logic [CW-1:0]        r_k;
    logic [CW-1:0]        r_cnt;

    // Division remainders.
    logic [W-1:0]         r_rn;
    logic [W-1:0]         r_rd;

    logic                 r_ovf_pend;

    // Output register.
    logic                 r_out_valid;
    logic [ACC_WIDTH-1:0] r_out_num;
    logic [ACC_WIDTH-1:0] r_out_den;
    fsa_pkg::t_ovf        r_out_ovf;

    logic [W-1:0]         run_num_x;
    logic [W-1:0]         run_den_x;
    logic [W:0]           diff_ba;
    logic [W:0]           diff_ab;
    logic [W:0]           tn;
    logic [W:0]           td;
    logic [W:0]           sub_n;
    logic [W:0]           sub_d;
    logic                 ge_n;
    logic                 ge_d;
    logic                 fits;
    logic                 result_ok;
    logic                 slot_free;
    logic [ACC_WIDTH-1:0] n_run_num;
    logic [ACC_WIDTH-1:0] n_run_den;

    assign run_num_x = {{(W - ACC_WIDTH){1'b0}}, r_run_num};
    assign run_den_x = {{(W - ACC_WIDTH){1'b0}}, r_run_den};

    // Both differences are formed at once; the borrow of b - a tells which operand is larger.
    assign diff_ba = {1'b0, r_b} - {1'b0, r_a};
    assign diff_ab = {1'b0, r_a} - {1'b0, r_b};

    // One restoring-division step for each quotient, sharing the divisor r_a.
    assign tn    = {r_rn, r_pn[W-1]};
    assign td    = {r_rd, r_pd[W-1]};
    assign sub_n = tn - {1'b0, r_a};
    assign sub_d = td - {1'b0, r_a};
    assign ge_n  = !sub_n[W];
    assign ge_d  = !sub_d[W];

    // The reduced sum is kept only if both quotients fit the accumulator.
    assign fits      = (r_pn[W-1:ACC_WIDTH] == '0) && (r_pd[W-1:ACC_WIDTH] == '0);
    assign result_ok = !r_ovf_pend && fits;
    assign n_run_num = result_ok ? r_pn[ACC_WIDTH-1:0] : r_run_num;
    assign n_run_den = result_ok ? r_pd[ACC_WIDTH-1:0] : r_run_den;

    assign slot_free = !r_out_valid || !i_stall;

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_sum_num  = r_out_num;
    assign o_sum_den  = r_out_den;
    assign o_overflow = (r_out_ovf == fsa_pkg::OVF_SET);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_run_num   <= '0;
            r_run_den   <= {{(ACC_WIDTH - 1){1'b0}}, 1'b1};
            r_out_valid <= 1'b0;
            r_ovf_pend  <= 1'b0;
        end else begin
            // In S_DONE the output register is reloaded below instead.
            if (r_out_valid && !i_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        // A restart clears the sum now, so an overflow later keeps 0/1.
                        if (i_restart) begin
                            r_run_num <= '0;
                            r_run_den <= {{(ACC_WIDTH - 1){1'b0}}, 1'b1};
                        end
                        r_sad <= i_addend_den;
                        r_san <= i_addend_num;
                        r_pn  <= '0;
                        r_pd  <= '0;
                        r_pt  <= '0;
                        r_cnt <= CW'(IN_WIDTH);
                        if (i_addend_den == '0) begin
                            r_ovf_pend <= 1'b1;
                            r_state    <= S_DONE;
                        end else begin
                            r_ovf_pend <= 1'b0;
                            r_state    <= S_MUL;
                        end
                    end
                end

                S_MUL: begin
                    // Shift-and-add over the addend bits for all three products.
                    r_pn  <= {r_pn[W-2:0], 1'b0} + (r_sad[IN_WIDTH-1] ? run_num_x : '0);
                    r_pd  <= {r_pd[W-2:0], 1'b0} + (r_sad[IN_WIDTH-1] ? run_den_x : '0);
                    r_pt  <= {r_pt[W-2:0], 1'b0} + (r_san[IN_WIDTH-1] ? run_den_x : '0);
                    r_sad <= {r_sad[IN_WIDTH-2:0], 1'b0};
                    r_san <= {r_san[IN_WIDTH-2:0], 1'b0};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin
                        r_state <= S_SUM;
                    end
                end

                S_SUM: begin
                    r_pn    <= r_pn + r_pt;
                    r_a     <= r_pn + r_pt;
                    r_b     <= r_pd;
                    r_k     <= '0;
                    r_state <= S_GZERO;
                end

                S_GZERO: begin
                    // A zero numerator has the denominator as its gcd.
                    if (r_a == '0) begin
                        r_a     <= r_b;
                        r_rn    <= '0;
                        r_rd    <= '0;
                        r_cnt   <= CW'(W);
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_GTWO;
                    end
                end

                S_GTWO: begin
                    if (!r_a[0] && !r_b[0]) begin
                        r_a <= {1'b0, r_a[W-1:1]};
                        r_b <= {1'b0, r_b[W-1:1]};
                        r_k <= r_k + 1'b1;
                    end else begin
                        r_state <= S_GAEVEN;
                    end
                end

                S_GAEVEN: begin
                    if (!r_a[0]) begin
                        r_a <= {1'b0, r_a[W-1:1]};
                    end else begin
                        r_state <= S_GLOOP;
                    end
                end

                S_GLOOP: begin
                    // a stays odd; b is halved while even, else the larger loses the smaller.
                    if (r_b == '0) begin
                        r_state <= S_GSHIFT;
                    end else if (!r_b[0]) begin
                        r_b <= {1'b0, r_b[W-1:1]};
                    end else if (diff_ba[W]) begin
                        r_a <= r_b;
                        r_b <= diff_ab[W-1:0];
                    end else begin
                        r_b <= diff_ba[W-1:0];
                    end
                end

                S_GSHIFT: begin
                    // Restore the common power of two.
                    if (r_k != '0) begin
                        r_a <= {r_a[W-2:0], 1'b0};
                        r_k <= r_k - 1'b1;
                    end else begin
                        r_rn    <= '0;
                        r_rd    <= '0;
                        r_cnt   <= CW'(W);
                        r_state <= S_DIV;
                    end
                end

                S_DIV: begin
                    r_rn  <= ge_n ? sub_n[W-1:0] : tn[W-1:0];
                    r_rd  <= ge_d ? sub_d[W-1:0] : td[W-1:0];
                    r_pn  <= {r_pn[W-2:0], ge_n};
                    r_pd  <= {r_pd[W-2:0], ge_d};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin
                        r_state <= S_DONE;
                    end
                end

                S_DONE: begin
                    if (slot_free) begin
                        r_run_num   <= n_run_num;
                        r_run_den   <= n_run_den;
                        r_out_num   <= n_run_num;
                        r_out_den   <= n_run_den;
                        r_out_ovf   <= result_ok ? fsa_pkg::OVF_NONE : fsa_pkg::OVF_SET;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // The divisor is never zero once division starts.
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_a != '0))
        else $error("gcd divisor is zero during division");

    // The main gcd loop keeps its first operand odd.
    a_gloop_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GLOOP) |-> r_a[0])
        else $error("gcd operand a is even in the subtract loop");

    // The running denominator can never become zero.
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run_den != '0))
        else $error("running denominator is zero");

    // An accepted transaction always starts work.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state != S_IDLE))
        else $error("accepted transaction did not leave idle");

    // A reported overflow leaves the running sum as it was shown.
    a_ovf_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && slot_free && !result_ok) |=>
        (r_run_num == $past(r_run_num)) && (r_run_den == $past(r_run_den)))
        else $error("running sum changed on overflow");

endmodule

`default_nettype wire

FILE: sim/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ACC_W = 32;
    localparam int IN_W  = 16;

    // Ends the run when neither channel completes a transaction for this many cycles.
    // It lies well above one accumulation, the longest sender gap and the single
    // long receiver hold-off (HOLD_CYCLES).
    localparam int IDLE_LIMIT = 20000;

    localparam int RANDOM_ITEMS  = 1300;
    localparam int HOLD_AFTER    = 200;
    localparam int HOLD_CYCLES   = 2500;
    localparam int DRAIN_CYCLES  = 400;
    localparam int MAX_REPORTS   = 40;

    typedef struct packed {
        logic            restart;
        logic [IN_W-1:0] num;
        logic [IN_W-1:0] den;
    } t_frac_item;

    typedef struct packed {
        logic [ACC_W-1:0] num;
        logic [ACC_W-1:0] den;
        fsa_pkg::t_ovf    ovf;
    } t_sum_result;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY
    } t_rx_mode;

    logic             i_clk        = 1'b0;
    logic             i_rst_n      = 1'b0;
    logic             in_valid     = 1'b0;
    logic             in_stall;
    logic             in_restart   = 1'b0;
    logic [IN_W-1:0]  in_num       = '0;
    logic [IN_W-1:0]  in_den       = '0;
    logic             out_valid;
    logic             out_stall    = 1'b0;
    logic [ACC_W-1:0] out_num;
    logic [ACC_W-1:0] out_den;
    logic             out_ovf;

    fraction_sum_accumulator_top #(
        .ACC_WIDTH (ACC_W),
        .IN_WIDTH  (IN_W)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (in_valid),
        .o_stall      (in_stall),
        .i_restart    (in_restart),
        .i_addend_num (in_num),
        .i_addend_den (in_den),
        .o_valid      (out_valid),
        .i_stall      (out_stall),
        .o_sum_num    (out_num),
        .o_sum_den    (out_den),
        .o_overflow   (out_ovf)
    );

    // Fractions waiting to be offered, and the sums the block owes us in order.
    t_frac_item  pending_q[$];
    t_sum_result owed_sums_q[$];

    // Our own copy of the running sum, advanced once per accepted transaction.
    logic [ACC_W-1:0] acc_num = '0;
    logic [ACC_W-1:0] acc_den = ACC_W'(1);

    int unsigned err_count     = 0;
    int unsigned items_sent    = 0;
    int unsigned items_total   = 0;
    int unsigned sums_seen     = 0;
    int unsigned restarts_sent = 0;
    int unsigned ovf_seen      = 0;
    int unsigned zero_den_sent = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction. The running sum is cleared on restart, then the addend
    // is cross-multiplied in at 64 bits, which holds the widest exact
    // intermediate (ACC_W + IN_W + 1 bits). Reduction uses the remainder
    // form of Euclid, which gives the same divisor as the binary gcd
    // in the hardware. A zero denominator, or a reduced sum that does not
    // fit the accumulator, leaves the running sum alone and flags overflow.
    // ------------------------------------------------------------------
    function automatic t_sum_result fold_fraction(input t_frac_item it);
        logic [63:0] numer;
        logic [63:0] denom;
        logic [63:0] ga;
        logic [63:0] gb;
        logic [63:0] rem;
        logic [63:0] red_num;
        logic [63:0] red_den;
        t_sum_result res;
        if (it.restart) begin
            acc_num = '0;
            acc_den = ACC_W'(1);
        end
        res.ovf = fsa_pkg::OVF_SET;
        if (it.den != '0) begin
            numer = 64'(acc_num) * 64'(it.den) + 64'(it.num) * 64'(acc_den);
            denom = 64'(acc_den) * 64'(it.den);
            ga = numer;
            gb = denom;
            while (gb != 0) begin
                rem = ga % gb;
                ga  = gb;
                gb  = rem;
            end
            red_num = numer / ga;
            red_den = denom / ga;
            if ((red_num >> ACC_W) == 0 && (red_den >> ACC_W) == 0) begin
                acc_num = red_num[ACC_W-1:0];
                acc_den = red_den[ACC_W-1:0];
                res.ovf = fsa_pkg::OVF_NONE;
            end
        end
        res.num = acc_num;
        res.den = acc_den;
        return res;
    endfunction

    // Prints one line per mismatch, up to a cap, and counts every one.
    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
    endtask

    task automatic add_item(input logic restart, input logic [IN_W-1:0] num,
                            input logic [IN_W-1:0] den);
        t_frac_item it;
        it.restart = restart;
        it.num     = num;
        it.den     = den;
        pending_q.push_back(it);
    endtask

    // Numerators lean toward small values and the extremes so that sums stay
    // in range long enough to exercise the reduction, but all bits toggle.
    function automatic logic [IN_W-1:0] pick_num();
        logic [IN_W-1:0] v;
        case ($urandom_range(0, 4))
            0: v = IN_W'($urandom_range(0, 15));
            1: v = IN_W'($urandom_range(0, 255));
            2: v = ($urandom_range(0, 1) != 0) ? '1 : '0;
            default: v = IN_W'($urandom);
        endcase
        return v;
    endfunction

    // Denominators: mostly nonzero, with small values, powers of two (which
    // stress the shift part of the gcd), the maximum, and an occasional zero.
    function automatic logic [IN_W-1:0] pick_den();
        logic [IN_W-1:0] v;
        case ($urandom_range(0, 31))
            0: v = '0;
            1, 2: v = '1;
            3, 4, 5, 6, 7, 8, 9, 10: v = IN_W'($urandom_range(1, 16));
            11, 12, 13, 14: v = IN_W'(1) << $urandom_range(0, IN_W - 1);
            15, 16, 17, 18, 19, 20: v = IN_W'($urandom_range(1, 1000));
            default: v = IN_W'($urandom_range(1, (1 << IN_W) - 1));
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial begin
        int unsigned n_random;
        int unsigned run_len;

        // Directed part: zero sums, extremes of both fields, gcd reduction,
        // zero denominators with and without restart, and denominator growth
        // that runs the reduced sum past the accumulator width.
        add_item(1'b0, 16'd0,     16'd1);
        add_item(1'b0, 16'd0,     16'hFFFF);
        add_item(1'b0, 16'hFFFF,  16'd1);
        add_item(1'b0, 16'hFFFF,  16'hFFFF);
        add_item(1'b0, 16'd1,     16'd0);
        add_item(1'b1, 16'd1,     16'd0);
        add_item(1'b1, 16'd2,     16'd4);
        add_item(1'b0, 16'd3,     16'd6);
        add_item(1'b0, 16'd0,     16'd0);
        add_item(1'b1, 16'd1,     16'hFFFF);
        add_item(1'b0, 16'd1,     16'hFFFE);
        add_item(1'b0, 16'd1,     16'hFFFD);
        add_item(1'b0, 16'd1,     16'hFFFB);
        add_item(1'b1, 16'hFFFF,  16'hFFFF);
        add_item(1'b1, 16'd1,     16'hFFFF);
        add_item(1'b0, 16'hFFFE,  16'hFFFD);
        add_item(1'b0, 16'hFFFF,  16'd1);
        add_item(1'b1, 16'hFFFF,  16'd1);
        add_item(1'b0, 16'hFFFF,  16'd2);
        add_item(1'b0, 16'h8000,  16'h8000);
        add_item(1'b1, 16'h5555,  16'hAAAA);
        add_item(1'b0, 16'hAAAA,  16'h5555);

        // Random part: mostly well-formed accumulations that start with a
        // restart, with some stray items mixed in.
        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                add_item(1'($urandom_range(0, 1)), IN_W'($urandom), IN_W'($urandom));
                n_random++;
            end else begin
                run_len = $urandom_range(1, 7);
                add_item(1'b1, pick_num(), pick_den());
                n_random++;
                repeat (run_len) begin
                    add_item(1'b0, pick_num(), pick_den());
                    n_random++;
                end
            end
        end
        items_total = pending_q.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every fraction went in and every sum came back, then
        // give the block time to show any stray result.
        while (items_sent < items_total || owed_sums_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (owed_sums_q.size() != 0) begin
            report_mismatch($sformatf("%0d sums never arrived", owed_sums_q.size()));
        end

        $display("Covered %0d fractions (%0d restarts, %0d zero denominators) and %0d sums,",
                 items_sent, restarts_sent, zero_den_sent, sums_seen);
        $display("of which %0d flagged overflow, with bursty input and one long output hold-off.",
                 ovf_seen);
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver. Offers queued fractions in bursts with gaps between them.
    // The payload holds while the block stalls; a new one is loaded only
    // after the previous transaction has gone through. The expected sum is
    // computed at the edge where the transaction is accepted.
    // ------------------------------------------------------------------
    t_frac_item  cur_item;
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                owed_sums_q.push_back(fold_fraction(cur_item));
                items_sent++;
                if (cur_item.restart) begin
                    restarts_sent++;
                end
                if (cur_item.den == '0) begin
                    zero_den_sent++;
                end
            end
            if (!in_valid || !in_stall) begin
                if (gap_left != 0) begin
                    in_valid <= 1'b0;
                    gap_left--;
                end else if (pending_q.size() != 0) begin
                    cur_item   = pending_q.pop_front();
                    in_valid   <= 1'b1;
                    in_restart <= cur_item.restart;
                    in_num     <= cur_item.num;
                    in_den     <= cur_item.den;
                    if (burst_left <= 1) begin
                        // End of a burst. Most gaps are short, some are long
                        // enough to fall on any phase of the block's work,
                        // and three bursts in ten run straight into the next.
                        burst_left = $urandom_range(1, 24);
                        case ($urandom_range(0, 9))
                            0, 1, 2: gap_left = 0;
                            3:       gap_left = $urandom_range(50, 400);
                            default: gap_left = $urandom_range(1, 12);
                        endcase
                    end else begin
                        burst_left--;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Long receiver hold-off, counted here on its own. It starts once a
    // couple of hundred sums have come back, while the sender keeps
    // offering, so the output register and the input side both fill up.
    // ------------------------------------------------------------------
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && sums_seen >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver stall pattern: it moves between free flow, light and heavy
    // stalling, staying in each mode for a random stretch.
    t_rx_mode    rx_mode   = RX_FREE;
    int unsigned mode_left = 0;
    logic        rx_pat;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 2));
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            case (rx_mode)
                RX_LIGHT: rx_pat = ($urandom_range(0, 99) < 30);
                RX_HEAVY: rx_pat = ($urandom_range(0, 99) < 75);
                default:  rx_pat = 1'b0;
            endcase
            out_stall <= (hold_left != 0) || rx_pat;
        end
    end

    // ------------------------------------------------------------------
    // Monitor. Every accepted result is checked field by field against the
    // oldest sum still owed.
    // ------------------------------------------------------------------
    t_sum_result want;

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) begin
            sums_seen++;
            if (out_ovf) begin
                ovf_seen++;
            end
            if (owed_sums_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0d/%0d ovf=%0b",
                                          out_num, out_den, out_ovf));
            end else begin
                want = owed_sums_q.pop_front();
                if (out_num !== want.num) begin
                    report_mismatch($sformatf("sum %0d: numerator %0d, expected %0d",
                                              sums_seen, out_num, want.num));
                end
                if (out_den !== want.den) begin
                    report_mismatch($sformatf("sum %0d: denominator %0d, expected %0d",
                                              sums_seen, out_den, want.den));
                end
                if (fsa_pkg::t_ovf'(out_ovf) !== want.ovf) begin
                    report_mismatch($sformatf("sum %0d: overflow %0b, expected %0b",
                                              sums_seen, out_ovf, want.ovf));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog. Counts cycles in which no transaction completes on either
    // channel and stops the run once that count reaches the limit.
    // ------------------------------------------------------------------
    int unsigned idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[%0t] watchdog: no transaction for %0d cycles", $realtime, idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

`default_nettype wire
